// File: sv/mub_pkg.sv
// shared types and constants for the masked integer upscale blit
// no dependencies; every other file takes names from here by scope
package mub_pkg;

	localparam int DEF_DISPLAY_WIDTH  = 1024;
	localparam int DEF_DISPLAY_HEIGHT = 600;
	localparam int DEF_MAX_REGIONS    = 4;
	localparam int DEF_MAX_SCALE      = 8;

	// job queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		REG_DEST_X0      = 3'd0,
		REG_DEST_Y0      = 3'd1,
		REG_SCALE        = 3'd2,
		REG_REGION_COUNT = 3'd3,
		REG_REGION_0     = 3'd4,
		REG_REGION_1     = 3'd5,
		REG_REGION_2     = 3'd6,
		REG_REGION_3     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [11:0] src_col;
		logic [11:0] src_row;
		logic [15:0] src_color;
	} pixel_t;

	typedef struct packed {
		logic [11:0] dst_col;
		logic [11:0] dst_row;
		logic [15:0] dst_color;
		logic        last_write;
	} result_t;

	// clipped destination block, inclusive bounds
	typedef struct packed {
		logic [11:0] xlo;
		logic [11:0] xhi;
		logic [11:0] ylo;
		logic [11:0] yhi;
		logic [15:0] color;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: sv/mub_front.sv
// front end: takes source pixels, tests the opaque rectangles, scales and clips
// depends on mub_pkg
module mub_front #(
	parameter int DISPLAY_WIDTH  = mub_pkg::DEF_DISPLAY_WIDTH,
	parameter int DISPLAY_HEIGHT = mub_pkg::DEF_DISPLAY_HEIGHT,
	parameter int MAX_REGIONS    = mub_pkg::DEF_MAX_REGIONS,
	parameter int MAX_SCALE      = mub_pkg::DEF_MAX_SCALE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  mub_pkg::pixel_t               pixel,
	output logic                          busy,
	input  logic signed [12:0]            dest_x0,
	input  logic signed [12:0]            dest_y0,
	input  logic [3:0]                    scale,
	input  logic [2:0]                    region_count,
	input  logic [MAX_REGIONS-1:0][63:0]  regions,
	input  mub_pkg::q_stat_t              q_stat,
	output logic                          push,
	output mub_pkg::job_t                 job
);

	localparam logic signed [16:0] W_S = 17'(DISPLAY_WIDTH);
	localparam logic signed [16:0] H_S = 17'(DISPLAY_HEIGHT);

	logic              accept;
	logic [3:0]        s_eff;
	logic [2:0]        cnt_eff;
	logic              hit;
	logic [14:0]       prod_x, prod_y;
	logic signed [16:0] bx, by;

	logic               v_s1;
	logic               hit_s1;
	logic signed [16:0] bx_s1, by_s1;
	logic [3:0]         s_s1;
	logic [15:0]        color_s1;

	logic signed [16:0] xe, ye;
	logic               empty_blk;
	logic               need;

	assign accept = start & ~busy;

	always_comb begin
		if (scale == 4'd0)
			s_eff = 4'd1;
		else if (scale > 4'(MAX_SCALE))
			s_eff = 4'(MAX_SCALE);
		else
			s_eff = scale;
		cnt_eff = (region_count > 3'(MAX_REGIONS)) ? 3'(MAX_REGIONS) : region_count;
	end

	// rectangles are tested side by side
	always_comb begin
		logic [16:0] lim_x, lim_y;
		logic [16:0] col_e, row_e;
		hit   = 1'b0;
		col_e = {5'b0, pixel.src_col};
		row_e = {5'b0, pixel.src_row};
		for (int i = 0; i < MAX_REGIONS; i++) begin
			lim_x = {1'b0, regions[i][15:0]} + {1'b0, regions[i][47:32]};
			lim_y = {1'b0, regions[i][31:16]} + {1'b0, regions[i][63:48]};
			if (i < int'(cnt_eff) &&
			    col_e >= {1'b0, regions[i][15:0]} && col_e < lim_x &&
			    row_e >= {1'b0, regions[i][31:16]} && row_e < lim_y)
				hit = 1'b1;
		end
	end

	assign prod_x = {3'b0, pixel.src_col} * {11'b0, s_eff};
	assign prod_y = {3'b0, pixel.src_row} * {11'b0, s_eff};
	assign bx = $signed({{4{dest_x0[12]}}, dest_x0}) + $signed({2'b0, prod_x});
	assign by = $signed({{4{dest_y0[12]}}, dest_y0}) + $signed({2'b0, prod_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept | busy;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1   <= hit;
			bx_s1    <= bx;
			by_s1    <= by;
			s_s1     <= s_eff;
			color_s1 <= pixel.src_color;
		end
	end

	// clip the block to the display
	assign xe = bx_s1 + $signed({13'b0, s_s1}) - 17'sd1;
	assign ye = by_s1 + $signed({13'b0, s_s1}) - 17'sd1;
	assign empty_blk = (xe < 17'sd0) || (bx_s1 >= W_S) || (ye < 17'sd0) || (by_s1 >= H_S);
	assign need = ~hit_s1 & ~empty_blk;

	assign busy = v_s1 & need & q_stat.full;
	assign push = v_s1 & need & ~q_stat.full;

	always_comb begin
		job.xlo   = (bx_s1 < 17'sd0) ? 12'd0 : bx_s1[11:0];
		job.ylo   = (by_s1 < 17'sd0) ? 12'd0 : by_s1[11:0];
		job.xhi   = (xe >= W_S) ? 12'(DISPLAY_WIDTH - 1) : xe[11:0];
		job.yhi   = (ye >= H_S) ? 12'(DISPLAY_HEIGHT - 1) : ye[11:0];
		job.color = color_s1;
	end

endmodule

// File: sv/mub_fifo.sv
// short job queue between the front and back ends
// depends on mub_pkg
module mub_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mub_pkg::job_t    wr_job,
	input  logic             pop,
	output mub_pkg::job_t    head,
	output mub_pkg::q_stat_t stat
);

	mub_pkg::job_t                  mem_q [mub_pkg::QDEPTH];
	logic [mub_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [mub_pkg::QCNT_W-1:0]     count_q;

	assign stat.full  = (count_q == mub_pkg::QCNT_W'(mub_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("job queue underflow");

endmodule

// File: sv/mub_back.sv
// back end: walks each clipped block row by row, one write per cycle while it holds a block
// depends on mub_pkg
module mub_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mub_pkg::job_t    head,
	input  mub_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             result_valid,
	output mub_pkg::result_t result
);

	logic        act_q;
	logic [11:0] x_q, y_q, xlo_q, xhi_q, yhi_q;
	logic [15:0] color_q;
	logic        last;
	logic        load;

	assign last = (x_q == xhi_q) && (y_q == yhi_q);
	assign load = ~q_stat.empty & (~act_q | last);
	assign pop  = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			act_q        <= load | (act_q & ~last);
			result_valid <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		if (act_q) begin
			result.dst_col    <= x_q;
			result.dst_row    <= y_q;
			result.dst_color  <= color_q;
			result.last_write <= last;
		end
		if (load) begin
			x_q     <= head.xlo;
			y_q     <= head.ylo;
			xlo_q   <= head.xlo;
			xhi_q   <= head.xhi;
			yhi_q   <= head.yhi;
			color_q <= head.color;
		end else if (act_q && !last) begin
			if (x_q == xhi_q) begin
				x_q <= xlo_q;
				y_q <= y_q + 12'd1;
			end else begin
				x_q <= x_q + 12'd1;
			end
		end
	end

	// writes of one block come without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_write |=> result_valid)
		else $error("gap inside a block");

endmodule

// File: sv/masked_integer_upscale_blit.sv
// a visible pixel passes the front stage register, the job queue and the back end position and
// output registers before its writes; throughput: one source pixel per cycle into the front while
// busy is low; the back end issues one write per cycle while it holds a block, one per pixel
// of the clipped block (at most MAX_SCALE squared); masked or off-display pixels give no writes;
// a 4-entry job queue decouples the two ends; writes cannot be held off by the receiver
// reset: arst_n asynchronous active low; registers return to origin 0, scale 1, no regions
module masked_integer_upscale_blit #(
	parameter int DISPLAY_WIDTH  = mub_pkg::DEF_DISPLAY_WIDTH,
	parameter int DISPLAY_HEIGHT = mub_pkg::DEF_DISPLAY_HEIGHT,
	parameter int MAX_REGIONS    = mub_pkg::DEF_MAX_REGIONS,
	parameter int MAX_SCALE      = mub_pkg::DEF_MAX_SCALE
) (
	input  logic             clk,
	input  logic             arst_n,
	// source pixel command
	input  logic             start,
	input  mub_pkg::pixel_t  pixel,
	output logic             busy,
	// configuration writes
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	// destination writes
	output logic             result_valid,
	output mub_pkg::result_t result
);

	// configuration registers
	logic signed [12:0]           dest_x0_q, dest_y0_q;
	logic [3:0]                   scale_q;
	logic [2:0]                   region_count_q;
	logic [MAX_REGIONS-1:0][63:0] region_q;

	// front to queue, queue to back
	logic             push, pop;
	mub_pkg::job_t    push_job, head_job;
	mub_pkg::q_stat_t q_stat;

	// scalar registers decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x0_q      <= '0;
			dest_y0_q      <= '0;
			scale_q        <= 4'd1;
			region_count_q <= '0;
		end else if (cfg_we) begin
			unique case (mub_pkg::cfg_reg_t'(cfg_index))
				mub_pkg::REG_DEST_X0:      dest_x0_q      <= cfg_data[12:0];
				mub_pkg::REG_DEST_Y0:      dest_y0_q      <= cfg_data[12:0];
				mub_pkg::REG_SCALE:        scale_q        <= cfg_data[3:0];
				mub_pkg::REG_REGION_COUNT: region_count_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// rectangle registers; rectangles past MAX_REGIONS are never enabled, so not kept
	for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_region
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				region_q[g] <= '0;
			end else if (cfg_we && cfg_index == 3'(int'(mub_pkg::REG_REGION_0) + g)) begin
				region_q[g] <= cfg_data;
			end
		end
	end

	// accept, mask test, scale and clip
	mub_front #(
		.DISPLAY_WIDTH (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT),
		.MAX_REGIONS   (MAX_REGIONS),
		.MAX_SCALE     (MAX_SCALE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.pixel       (pixel),
		.busy        (busy),
		.dest_x0     (dest_x0_q),
		.dest_y0     (dest_y0_q),
		.scale       (scale_q),
		.region_count(region_count_q),
		.regions     (region_q),
		.q_stat      (q_stat),
		.push        (push),
		.job         (push_job)
	);

	// clipped blocks waiting for the back end
	mub_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(push_job),
		.pop   (pop),
		.head  (head_job),
		.stat  (q_stat)
	);

	// one destination write transfer per cycle while a block is in hand
	mub_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_job),
		.q_stat      (q_stat),
		.pop         (pop),
		.result_valid(result_valid),
		.result      (result)
	);

	// every write lands on the display
	a_on_display: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.dst_col <= 12'(DISPLAY_WIDTH - 1)) &&
		                 (result.dst_row <= 12'(DISPLAY_HEIGHT - 1)))
		else $error("write outside the display");

endmodule
